/* sv/rgbm_pkg.sv */
// Shared types and constants for the RGB matrix scan controller.
package rgbm_pkg;

  localparam logic [2:0] OP_SET_PIXEL = 3'd0;
  localparam logic [2:0] OP_FLIP      = 3'd1;
  localparam logic [2:0] OP_FLIP_COPY = 3'd2;
  localparam logic [2:0] OP_FILL_FLIP = 3'd3;
  localparam logic [2:0] OP_ROW_TICK  = 3'd4;
  localparam logic [2:0] OP_WB_SEND   = 3'd5;

  localparam logic [1:0] CFG_WB_RED   = 2'd0;
  localparam logic [1:0] CFG_WB_GREEN = 2'd1;
  localparam logic [1:0] CFG_WB_BLUE  = 2'd2;

  localparam int SLOT_BITS   = 6;
  localparam int ADDR_BITS   = SLOT_BITS + 1;
  localparam int PIXEL_BITS  = 24;
  localparam int STORE_DEPTH = 2 ** ADDR_BITS;
  localparam int WB_BITS     = 6;

  localparam logic [3:0] ROWS_OFF = 4'd8;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;

  // Frame memory port request from the sequencer
  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    pixel_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } mem_req_t;

  // Description of one result item travelling down the output pipeline
  typedef struct packed {
    logic       corr;
    logic       blank;
    logic       fin;
    logic [3:0] row_enable;
  } res_tag_t;

endpackage

/* sv/rgbm_if.sv */
// Handshake channel interfaces for command items and result items.
interface rgbm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [3:0] x_coord;
  logic [3:0] y_coord;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output opcode, output x_coord, output y_coord,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input opcode, input x_coord, input y_coord,
                  input red, input green, input blue, output ready);
endinterface

interface rgbm_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] shift_word;
  logic [4:0]  shift_bits;
  logic        correction_bank;
  logic [3:0]  row_enable;
  logic        latch_pulse;
  logic        last;

  modport source (output valid, output shift_word, output shift_bits,
                  output correction_bank, output row_enable, output latch_pulse,
                  output last, input ready);
  modport sink   (input valid, input shift_word, input shift_bits,
                  input correction_bank, input row_enable, input latch_pulse,
                  input last, output ready);
endinterface

/* sv/rgbm_frame_mem.sv */
// Frame memory: two buffers of pixels, one write and one registered read port.
module rgbm_frame_mem (
  input  logic              clk,
  input  logic              rst,
  input  rgbm_pkg::mem_req_t req,
  output rgbm_pkg::pixel_t   rd_data
);
  import rgbm_pkg::*;

  pixel_t                 mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  pixel_t                 rd_raw;
  logic                   rd_ok;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_addr];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= written[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_raw : '0;

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    req.rd_en && req.wr_en |-> req.rd_addr != req.wr_addr)
    else $error("frame memory read and write hit the same entry");

endmodule

/* sv/rgbm_seq.sv */
// Command sequencer: decodes items and drives frame memory sweeps and result issue.
module rgbm_seq #(
  parameter int SCREEN_WIDTH  = 8,
  parameter int SCREEN_HEIGHT = 8
) (
  input  logic               clk,
  input  logic               rst,
  rgbm_in_if.sink            cmd,
  input  logic               issue_ok,
  output logic               issue,
  output rgbm_pkg::res_tag_t tag,
  output rgbm_pkg::mem_req_t mem_req,
  input  rgbm_pkg::pixel_t   mem_rd_data
);
  import rgbm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COPY = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_ROW  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  localparam slot_t PIX_LAST = slot_t'(SCREEN_WIDTH * SCREEN_HEIGHT - 1);
  localparam slot_t ROW_LAST = slot_t'(SCREEN_WIDTH - 1);
  localparam slot_t WB_LAST  = slot_t'(SCREEN_HEIGHT - 1);

  logic [2:0] state;
  logic       active;
  logic [2:0] row_counter;
  slot_t      cnt;
  pixel_t     fill_colour;
  logic       cp_wr_pend;
  addr_t      cp_wr_addr;

  logic   accept;
  logic   on_screen;
  slot_t  set_slot;
  slot_t  row_slot;
  pixel_t colour;
  logic   pix_last;
  logic   row_last;
  logic   wb_last;

  // Take items when idle, no copy write is pending and the output pipe has room
  assign cmd.ready = (state == ST_IDLE) && !cp_wr_pend && issue_ok;
  assign accept    = cmd.valid && cmd.ready;
  assign colour    = {cmd.blue, cmd.green, cmd.red};
  assign on_screen = (int'(cmd.x_coord) < SCREEN_WIDTH) && (int'(cmd.y_coord) < SCREEN_HEIGHT);
  assign set_slot  = slot_t'(int'(cmd.y_coord) * SCREEN_WIDTH + int'(cmd.x_coord));
  assign row_slot  = slot_t'(int'(row_counter) * SCREEN_WIDTH + int'(cnt));
  assign pix_last  = (cnt == PIX_LAST);
  assign row_last  = (cnt == ROW_LAST);
  assign wb_last   = (cnt == WB_LAST);

  assign issue = ((state == ST_ROW) || (state == ST_WB)) && issue_ok;

  always_comb begin
    tag.corr       = (state == ST_WB);
    tag.blank      = (int'(row_counter) >= SCREEN_HEIGHT);
    tag.fin        = (state == ST_ROW) ? row_last : wb_last;
    tag.row_enable = ((state == ST_ROW) && row_last) ? {1'b0, row_counter} : ROWS_OFF;
  end

  always_comb begin
    mem_req = '0;
    // read the shown buffer: row words, or the source side of a copy
    if (state == ST_COPY) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = {active, cnt};
    end else begin
      mem_req.rd_en   = issue && (state == ST_ROW);
      mem_req.rd_addr = {active, row_slot};
    end
    priority if (cp_wr_pend) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = cp_wr_addr;
      mem_req.wr_data = mem_rd_data;
    end else if (state == ST_FILL) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = {~active, cnt};
      mem_req.wr_data = fill_colour;
    end else if (accept && (cmd.opcode == OP_SET_PIXEL) && on_screen) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = {~active, set_slot};
      mem_req.wr_data = colour;
    end
  end

  // Copy write trails its read by the memory latency
  always_ff @(posedge clk) begin
    cp_wr_addr <= {~active, cnt};
    if (accept) begin
      fill_colour <= colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= 1'b0;
      row_counter <= 3'd0;
      cnt         <= '0;
      cp_wr_pend  <= 1'b0;
    end else begin
      cp_wr_pend <= (state == ST_COPY);
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            unique case (cmd.opcode)
              OP_FLIP: begin
                active <= ~active;
              end
              OP_FLIP_COPY: begin
                active <= ~active;
                state  <= ST_COPY;
              end
              OP_FILL_FLIP: begin
                state <= ST_FILL;
              end
              OP_ROW_TICK: begin
                state <= ST_ROW;
              end
              OP_WB_SEND: begin
                state <= ST_WB;
              end
              default: begin
              end
            endcase
          end
        end
        ST_COPY: begin
          cnt <= cnt + 1'b1;
          if (pix_last) begin
            state <= ST_IDLE;
          end
        end
        ST_FILL: begin
          cnt <= cnt + 1'b1;
          if (pix_last) begin
            active <= ~active;
            state  <= ST_IDLE;
          end
        end
        ST_ROW: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
            if (row_last) begin
              row_counter <= row_counter + 3'd1;
              state       <= ST_IDLE;
            end
          end
        end
        ST_WB: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
            if (wb_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_copy_into_hidden: assert property (@(posedge clk) disable iff (rst)
    cp_wr_pend |-> cp_wr_addr[ADDR_BITS-1] != active)
    else $error("copy write lands in the shown buffer");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW) && issue && row_last |=> row_counter == $past(row_counter) + 3'd1)
    else $error("row counter did not advance after a row tick");

endmodule

/* sv/rgbm_out_stage.sv */
// Result pipeline: aligns memory data with its tag, formats words, holds the output register.
module rgbm_out_stage #(
  parameter int COLOR_BITS      = 8,
  parameter int CORRECTION_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               issue,
  input  rgbm_pkg::res_tag_t tag,
  output logic               issue_ok,
  input  rgbm_pkg::pixel_t   rd_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  rgbm_out_if.source         res
);
  import rgbm_pkg::*;

  localparam int CB = COLOR_BITS;
  localparam int KB = CORRECTION_BITS;

  logic [WB_BITS-1:0] wb_red;
  logic [WB_BITS-1:0] wb_green;
  logic [WB_BITS-1:0] wb_blue;

  logic     s1_valid;
  res_tag_t s1_tag;
  logic     s1_move;
  pixel_t   px;
  pixel_t   pix_word;
  pixel_t   corr_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_red   <= '1;
      wb_green <= '1;
      wb_blue  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WB_RED:   wb_red   <= cfg_data;
        CFG_WB_GREEN: wb_green <= cfg_data;
        CFG_WB_BLUE:  wb_blue  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1_move  = s1_valid && (!res.valid || res.ready);
  assign issue_ok = !s1_valid || s1_move;

  assign px = s1_tag.blank ? '0 : rd_data;

  assign pix_word = ((pixel_t'(px[23:16]) >> (8 - CB)) << (2 * CB))
                  | ((pixel_t'(px[15:8])  >> (8 - CB)) << CB)
                  |  (pixel_t'(px[7:0])   >> (8 - CB));

  assign corr_word = ((pixel_t'(wb_blue)  >> (WB_BITS - KB)) << (2 * KB))
                   | ((pixel_t'(wb_green) >> (WB_BITS - KB)) << KB)
                   |  (pixel_t'(wb_red)   >> (WB_BITS - KB));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (issue_ok) begin
        s1_valid <= issue;
      end
      if (s1_move) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_tag <= tag;
    end
    if (s1_move) begin
      res.shift_word      <= s1_tag.corr ? corr_word : pix_word;
      res.shift_bits      <= s1_tag.corr ? 5'(3 * KB) : 5'(3 * CB);
      res.correction_bank <= s1_tag.corr;
      res.row_enable      <= s1_tag.row_enable;
      res.latch_pulse     <= s1_tag.fin;
      res.last            <= s1_tag.fin;
    end
  end

  a_corr_rows_off: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.correction_bank |-> res.row_enable == ROWS_OFF)
    else $error("correction word drives a row");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_tag))
    else $error("stalled result stage lost its item");

endmodule

/* sv/rgb_matrix_scan_controller.sv */
// Top level of the RGB matrix scan controller.
// Set pixel and flip act on accept; a row tick sends SCREEN_WIDTH words, one word per cycle
// while the output pipe has room, and white balance sends SCREEN_HEIGHT words likewise.
// Flip-and-copy and fill hold off input while they sweep the frame memory; input also
// holds while a result stalls in the output pipe.
// Reset: synchronous; buffers read as zero via per-entry written flags, no clear sweep.
module rgb_matrix_scan_controller #(
  parameter int SCREEN_WIDTH    = 8,
  parameter int SCREEN_HEIGHT   = 8,
  parameter int COLOR_BITS      = 8,
  parameter int CORRECTION_BITS = 6
) (
  input  logic       clk,
  input  logic       rst,
  rgbm_in_if.sink    cmd,
  rgbm_out_if.source res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);
  import rgbm_pkg::*;

  // Memory request from the sequencer; registered read data shared by the sequencer and output pipe
  mem_req_t mem_req;
  pixel_t   mem_rd_data;

  // Result issue handshake between sequencer and output pipe
  logic     issue;
  logic     issue_ok;
  res_tag_t tag;

  // Hold both frame buffers; read data is registered, so a pixel read issued
  // in one cycle reaches the output pipe in the next.
  rgbm_frame_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // Decode items, run the copy and fill sweeps, and issue row or correction
  // results one per cycle while the output pipe has room.
  rgbm_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .issue_ok    (issue_ok),
    .issue       (issue),
    .tag         (tag),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  // Format words, hold the correction registers and the output register; a
  // stall on the result side backs up into the sequencer through issue_ok.
  rgbm_out_stage #(
    .COLOR_BITS      (COLOR_BITS),
    .CORRECTION_BITS (CORRECTION_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .tag       (tag),
    .issue_ok  (issue_ok),
    .rd_data   (mem_rd_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  a_last_latches: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last && !res.correction_bank |-> res.row_enable != ROWS_OFF)
    else $error("last word of a row tick does not enable a row");

endmodule

/* test/tb_rgb_matrix_scan_controller.sv */
// Self-checking testbench for the RGB matrix scan controller: directed table, then random phases.
`timescale 1ns / 1ps

module tb_rgb_matrix_scan_controller;
  import rgbm_pkg::*;

  localparam int SCREEN_W    = 8;
  localparam int SCREEN_H    = 8;
  localparam int COLOR_W     = 8;
  localparam int CORR_W      = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  // Slack after the last result before touching config or ending the run;
  // covers a fill or copy still sweeping the frame memory.
  localparam int SETTLE_CYCLES = 100;

  // Opcodes the block has no operation for
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // One serialized word leaving the block
  typedef struct packed {
    logic [23:0] word;
    logic [4:0]  bits;
    logic        bank;
    logic [3:0]  row;
    logic        latch;
    logic        fin;
  } scan_word_t;

  // One command item; pinned marks a row whose shift_word is typed in
  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        pinned;
    logic [23:0] word;
  } cmd_item_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  rgbm_in_if  cmd_ch ();
  rgbm_out_if res_ch ();

  rgb_matrix_scan_controller #(
    .SCREEN_WIDTH   (SCREEN_W),
    .SCREEN_HEIGHT  (SCREEN_H),
    .COLOR_BITS     (COLOR_W),
    .CORRECTION_BITS(CORR_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the controller state
  logic [23:0] frame_mem [128];
  logic        shown_buf;
  logic [2:0]  scan_row;
  logic [5:0]  wb_red_q, wb_green_q, wb_blue_q;

  scan_word_t  expected_words [$];
  int          fails = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int unsigned cycle_count = 0;

  // Directed items: extremes, every opcode, off-screen pixels, spare opcodes, row wrap
  cmd_item_t directed_table [25] = '{
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'h000000}, // reset: black
    '{OP_WB_SEND,   4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'h03FFFF}, // reset: all 63
    '{OP_SET_PIXEL, 4'd0,  4'd0,  8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0},
    '{OP_SET_PIXEL, 4'd7,  4'd7,  8'h12, 8'h34, 8'h56, 1'b0, 24'h0},
    '{OP_SET_PIXEL, 4'd7,  4'd0,  8'hFF, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_SET_PIXEL, 4'd0,  4'd7,  8'h00, 8'h00, 8'hFF, 1'b0, 24'h0},
    '{OP_SET_PIXEL, 4'd8,  4'd0,  8'hAA, 8'hAA, 8'hAA, 1'b0, 24'h0},
    '{OP_SET_PIXEL, 4'd0,  4'd8,  8'h55, 8'h55, 8'h55, 1'b0, 24'h0},
    '{OP_SET_PIXEL, 4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'h000000}, // shown still blank
    '{OP_FLIP,      4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_SPARE_6,   4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0},
    '{OP_SPARE_7,   4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0},
    '{OP_FILL_FLIP, 4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'hFFFFFF}, // full white
    '{OP_FLIP_COPY, 4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_SET_PIXEL, 4'd7,  4'd5,  8'h01, 8'h80, 8'h7F, 1'b0, 24'h0},
    '{OP_FLIP,      4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_FILL_FLIP, 4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 24'h0},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
    '{OP_ROW_TICK,  4'd0,  4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 24'h000000}  // row wraps to 0
  };

  // Frame memory address of pixel (x, y) in buffer b
  function automatic int slot_of(logic b, int x, int y);
    return (int'(b) * 64 + y * SCREEN_W + x) & 127;
  endfunction

  // Keep the top n bits of an 8-bit colour, right aligned
  function automatic logic [23:0] top_bits(logic [7:0] v, int n);
    return 24'(v >> (8 - n));
  endfunction

  // Apply one accepted item to the shadow state and queue the words it produces
  task automatic advance_scan_model(input cmd_item_t c);
    logic        hidden;
    logic [23:0] px;
    logic [23:0] wd;
    scan_word_t  w;
    int          row;
    int          i, j, k;
    hidden = ~shown_buf;
    case (c.op)
      OP_SET_PIXEL: begin
        if (c.x < SCREEN_W && c.y < SCREEN_H)
          frame_mem[slot_of(hidden, int'(c.x), int'(c.y))] = {c.b, c.g, c.r};
      end
      OP_FLIP: shown_buf = hidden;
      OP_FLIP_COPY: begin
        shown_buf = hidden;
        for (j = 0; j < SCREEN_H; j++)
          for (i = 0; i < SCREEN_W; i++)
            frame_mem[slot_of(~shown_buf, i, j)] = frame_mem[slot_of(shown_buf, i, j)];
      end
      OP_FILL_FLIP: begin
        for (j = 0; j < SCREEN_H; j++)
          for (i = 0; i < SCREEN_W; i++)
            frame_mem[slot_of(hidden, i, j)] = {c.b, c.g, c.r};
        shown_buf = hidden;
      end
      OP_ROW_TICK: begin
        row = int'(scan_row);
        for (k = 0; k < SCREEN_W; k++) begin
          px = (row < SCREEN_H) ? frame_mem[slot_of(shown_buf, k, row)] : 24'h0;
          wd = (top_bits(px[23:16], COLOR_W) << (2 * COLOR_W))
             | (top_bits(px[15:8], COLOR_W) << COLOR_W)
             | top_bits(px[7:0], COLOR_W);
          w.word  = c.pinned ? c.word : wd;
          w.bits  = 5'(3 * COLOR_W);
          w.bank  = 1'b0;
          w.fin   = (k == SCREEN_W - 1);
          w.latch = w.fin;
          w.row   = w.fin ? 4'(row) : ROWS_OFF;
          expected_words.push_back(w);
        end
        scan_row = scan_row + 3'd1;
      end
      OP_WB_SEND: begin
        wd = (24'(wb_blue_q >> (6 - CORR_W)) << (2 * CORR_W))
           | (24'(wb_green_q >> (6 - CORR_W)) << CORR_W)
           | 24'(wb_red_q >> (6 - CORR_W));
        for (k = 0; k < SCREEN_H; k++) begin
          w.word  = c.pinned ? c.word : wd;
          w.bits  = 5'(3 * CORR_W);
          w.bank  = 1'b1;
          w.row   = ROWS_OFF;
          w.fin   = (k == SCREEN_H - 1);
          w.latch = w.fin;
          expected_words.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  // Random command item; mostly pixel writes and row ticks, some noise
  function automatic cmd_item_t random_item();
    cmd_item_t c;
    int        pick;
    pick = $urandom_range(99);
    c.x  = 4'($urandom_range(7));
    c.y  = 4'($urandom_range(7));
    c.r  = 8'($urandom_range(255));
    c.g  = 8'($urandom_range(255));
    c.b  = 8'($urandom_range(255));
    c.pinned = 1'b0;
    c.word   = 24'h0;
    if (pick < 40) c.op = OP_SET_PIXEL;
    else if (pick < 62) c.op = OP_ROW_TICK;
    else if (pick < 72) c.op = OP_WB_SEND;
    else if (pick < 80) c.op = OP_FLIP;
    else if (pick < 84) c.op = OP_FLIP_COPY;
    else if (pick < 88) c.op = OP_FILL_FLIP;
    else if (pick < 93) c.op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
    else begin
      // off-screen or any-coordinate pixel write
      c.op = OP_SET_PIXEL;
      c.x  = 4'($urandom_range(15));
      c.y  = 4'($urandom_range(15));
    end
    return c;
  endfunction

  // Offer one item at falling edges, with random gaps; predict on accept
  task automatic send_item(input cmd_item_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= c.op;
    cmd_ch.x_coord <= c.x;
    cmd_ch.y_coord <= c.y;
    cmd_ch.red     <= c.r;
    cmd_ch.green   <= c.g;
    cmd_ch.blue    <= c.b;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    advance_scan_model(c);
  endtask

  // Drop valid and wait until every queued word has come out
  task automatic wait_drained(input bit settle);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_WB_RED:   wb_red_q   = val;
      CFG_WB_GREEN: wb_green_q = val;
      CFG_WB_BLUE:  wb_blue_q  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random phase; pause_at >= 0 makes the sender wait for an empty pipeline there
  task automatic run_random(input int count, input int pause_at);
    int n;
    for (n = 0; n < count; n++) begin
      if (n == pause_at) wait_drained(1'b0);
      send_item(random_item());
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Free-running cycle count; end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result sink: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare every accepted result item with the oldest queued word
  always @(posedge clk) begin : result_monitor
    scan_word_t head;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result item: shift_word %0h", res_ch.shift_word);
        fails++;
      end else begin
        head = expected_words.pop_front();
        check_field("shift_word", head.word, res_ch.shift_word);
        check_field("shift_bits", 24'(head.bits), 24'(res_ch.shift_bits));
        check_field("correction_bank", 24'(head.bank), 24'(res_ch.correction_bank));
        check_field("row_enable", 24'(head.row), 24'(res_ch.row_enable));
        check_field("latch_pulse", 24'(head.latch), 24'(res_ch.latch_pulse));
        check_field("last", 24'(head.fin), 24'(res_ch.last));
      end
    end
  end

  initial begin : stimulus
    int n;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_WB_RED;
    cfg_data       <= 6'd0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.opcode  <= OP_SET_PIXEL;
    cmd_ch.x_coord <= 4'd0;
    cmd_ch.y_coord <= 4'd0;
    cmd_ch.red     <= 8'd0;
    cmd_ch.green   <= 8'd0;
    cmd_ch.blue    <= 8'd0;
    hold_req  = 1'b0;
    shown_buf = 1'b0;
    scan_row  = 3'd0;
    wb_red_q   = 6'd63;
    wb_green_q = 6'd63;
    wb_blue_q  = 6'd63;
    for (n = 0; n < 128; n++) frame_mem[n] = 24'h0;

    // Phase 1 idling: sender rarely idles, receiver mostly stalls
    send_idle_pct = 6;
    recv_idle_pct = 71;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part runs with the reset correction values
    for (n = 0; n < $size(directed_table); n++) send_item(directed_table[n]);
    wait_drained(1'b1);

    // Low extreme for all corrections
    write_reg(CFG_WB_RED, 6'd0);
    write_reg(CFG_WB_GREEN, 6'd0);
    write_reg(CFG_WB_BLUE, 6'd0);
    run_random(125, -1);
    wait_drained(1'b1);

    // Phase 2: swap idling; random corrections; sender pauses midway for a full drain
    send_idle_pct = 71;
    recv_idle_pct = 6;
    write_reg(CFG_WB_RED, 6'($urandom_range(63)));
    write_reg(CFG_WB_GREEN, 6'($urandom_range(63)));
    write_reg(CFG_WB_BLUE, 6'($urandom_range(63)));
    run_random(125, 60);
    wait_drained(1'b1);

    // Phase 3: no idling; receiver holds off long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_WB_RED, 6'd63);
    write_reg(CFG_WB_GREEN, 6'h2A);
    write_reg(CFG_WB_BLUE, 6'h15);
    hold_req = 1'b1;
    run_random(125, -1);
    wait_drained(1'b1);

    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
sv/rgbm_pkg.sv
sv/rgbm_if.sv
sv/rgbm_frame_mem.sv
sv/rgbm_seq.sv
sv/rgbm_out_stage.sv
sv/rgb_matrix_scan_controller.sv
test/tb_rgb_matrix_scan_controller.sv
